### rtl/core/rrs_pkg.sv
// Shared types and constants for the round-robin scheduler core.
// No dependencies; compiled first.
package rrs_pkg;

    localparam int MAX_PROC_DEF = 16;   // default table depth
    localparam int TIME_W       = 16;   // burst time / slice width
    localparam int ID_W         = 5;    // process id width
    localparam int SCAN_MAX     = 16;   // upper bound on slots checked per search cycle

    localparam logic [TIME_W-1:0] SLICE_RESET = TIME_W'(1);

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_RUN = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture the incoming item
        logic start_scan;  // search starts at the current position
        logic scan_step;   // advance search window
        logic scan_hit;    // latch found slot, launch memory read
        logic set_none;    // result: nothing active
        logic do_add;      // add process or flag table full
        logic do_exec;     // apply slice to the found slot
        logic emit;        // move staged result to output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic found;       // active slot in current window
        logic last_step;   // window covers the end of the search
        logic out_free;    // output register can take a result
    } t_dp_sts;

endpackage

### rtl/core/rrs_in_if.sv
// Input channel of the scheduler: valid/ready plus mode and burst time.
// Depends on rrs_pkg.
interface rrs_in_if;
    import rrs_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [TIME_W-1:0] burst_time;

    modport source (output valid, output mode, output burst_time, input ready);
    modport sink   (input valid, input mode, input burst_time, output ready);
endinterface

### rtl/core/rrs_out_if.sv
// Result channel of the scheduler: valid/ready plus the result fields.
// Depends on rrs_pkg.
interface rrs_out_if;
    import rrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   process_id;
    logic              completed;
    logic [TIME_W-1:0] time_left;
    logic              no_process;
    logic              table_full;

    modport source (output valid, output process_id, output completed, output time_left,
                    output no_process, output table_full, input ready);
    modport sink   (input valid, input process_id, input completed, input time_left,
                    input no_process, input table_full, output ready);
endinterface

### rtl/core/rrs_datapath.sv
// Scheduler datapath: process table, active bits, windowed slot search,
// slice arithmetic and the result register. Depends on rrs_pkg, rrs_out_if.
module rrs_datapath #(
    parameter int MAX_PROCESSES = rrs_pkg::MAX_PROC_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rrs_pkg::TIME_W-1:0]  i_cfg_wdata,
    input  logic                        i_mode,
    input  logic [rrs_pkg::TIME_W-1:0]  i_burst_time,
    input  rrs_pkg::t_dp_cmd            i_cmd,
    output rrs_pkg::t_dp_sts            o_sts,
    rrs_out_if.source                   o_result
);
    import rrs_pkg::*;

    localparam int SLOT_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int SCAN_W = (MAX_PROCESSES < SCAN_MAX) ? MAX_PROCESSES : SCAN_MAX;
    localparam int NSTEP  = (MAX_PROCESSES + SCAN_W - 1) / SCAN_W;
    localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    localparam logic [SLOT_W:0] DEPTH = (SLOT_W + 1)'(MAX_PROCESSES);

    // state
    logic [TIME_W-1:0]        r_slice;
    logic [CNT_W-1:0]         r_free;
    logic [SLOT_W-1:0]        r_cur;
    logic [MAX_PROCESSES-1:0] r_active;
    logic [TIME_W-1:0]        r_mem [MAX_PROCESSES];
    logic [TIME_W-1:0]        r_rd_data;

    // item and search
    logic                     r_mode;
    logic [TIME_W-1:0]        r_burst;
    logic [SLOT_W-1:0]        r_pos;
    logic [STEP_W-1:0]        r_step;
    logic [SLOT_W-1:0]        r_slot;

    // staged and output result
    logic [ID_W-1:0]          r_res_id;
    logic                     r_res_done;
    logic [TIME_W-1:0]        r_res_left;
    logic                     r_res_none;
    logic                     r_res_full;
    logic                     r_out_valid;
    logic [ID_W-1:0]          r_out_id;
    logic                     r_out_done;
    logic [TIME_W-1:0]        r_out_left;
    logic                     r_out_none;
    logic                     r_out_full;

    logic [SLOT_W:0]          w_idx [SCAN_W];
    logic [SLOT_W-1:0]        w_cand [SCAN_W];
    logic                     w_hit;
    logic [SLOT_W-1:0]        w_hit_slot;
    logic [SLOT_W:0]          w_pos_sum;
    logic [SLOT_W-1:0]        w_pos_next;
    logic [SLOT_W:0]          w_cur_sum;
    logic [SLOT_W-1:0]        w_cur_next;
    logic                     w_full;
    logic [SLOT_W-1:0]        w_free_slot;
    logic                     w_done;
    logic [TIME_W-1:0]        w_left;
    logic                     w_wr_en;
    logic [SLOT_W-1:0]        w_wr_addr;
    logic [TIME_W-1:0]        w_wr_data;

    // search window: SCAN_W slots from r_pos, wrapping at the table end
    for (genvar k = 0; k < SCAN_W; k++) begin : g_win
        always_comb begin
            w_idx[k] = {1'b0, r_pos} + (SLOT_W + 1)'(k);
            if (w_idx[k] >= DEPTH) begin
                w_idx[k] = w_idx[k] - DEPTH;
            end
            w_cand[k] = w_idx[k][SLOT_W-1:0];
        end
    end

    // first active slot in window order
    always_comb begin
        w_hit      = 1'b0;
        w_hit_slot = '0;
        for (int k = SCAN_W - 1; k >= 0; k--) begin
            if (r_active[w_cand[k]]) begin
                w_hit      = 1'b1;
                w_hit_slot = w_cand[k];
            end
        end
    end

    always_comb begin
        w_pos_sum = {1'b0, r_pos} + (SLOT_W + 1)'(SCAN_W);
        if (w_pos_sum >= DEPTH) begin
            w_pos_sum = w_pos_sum - DEPTH;
        end
        w_pos_next = w_pos_sum[SLOT_W-1:0];

        w_cur_sum = {1'b0, r_slot} + (SLOT_W + 1)'(1);
        if (w_cur_sum >= DEPTH) begin
            w_cur_sum = '0;
        end
        w_cur_next = w_cur_sum[SLOT_W-1:0];
    end

    assign w_full      = (r_free >= CNT_W'(MAX_PROCESSES));
    assign w_free_slot = r_free[SLOT_W-1:0];
    assign w_done      = (r_rd_data <= r_slice);
    assign w_left      = r_rd_data - r_slice;

    assign w_wr_en   = (i_cmd.do_add && !w_full) || i_cmd.do_exec;
    assign w_wr_addr = i_cmd.do_exec ? r_slot : w_free_slot;
    assign w_wr_data = i_cmd.do_exec ? (w_done ? '0 : w_left) : r_burst;

    // process table, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.scan_hit) begin
            r_rd_data <= r_mem[w_hit_slot];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice     <= SLICE_RESET;
            r_free      <= '0;
            r_cur       <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slice <= i_cfg_wdata;
            end
            if (i_cmd.do_add && !w_full) begin
                r_active[w_free_slot] <= 1'b1;
                r_free                <= r_free + CNT_W'(1);
            end
            if (i_cmd.do_exec) begin
                r_cur <= w_cur_next;
                if (w_done) begin
                    r_active[r_slot] <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode  <= i_mode;
            r_burst <= i_burst_time;
        end
        if (i_cmd.start_scan) begin
            r_pos  <= r_cur;
            r_step <= '0;
        end else if (i_cmd.scan_step) begin
            r_pos  <= w_pos_next;
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.scan_hit) begin
            r_slot <= w_hit_slot;
        end

        if (i_cmd.do_add) begin
            r_res_id   <= w_full ? '0 : ID_W'({1'b0, w_free_slot} + (SLOT_W + 1)'(1));
            r_res_done <= 1'b0;
            r_res_left <= w_full ? '0 : r_burst;
            r_res_none <= 1'b0;
            r_res_full <= w_full;
        end else if (i_cmd.set_none) begin
            r_res_id   <= '0;
            r_res_done <= 1'b0;
            r_res_left <= '0;
            r_res_none <= 1'b1;
            r_res_full <= 1'b0;
        end else if (i_cmd.do_exec) begin
            r_res_id   <= ID_W'({1'b0, r_slot} + (SLOT_W + 1)'(1));
            r_res_done <= w_done;
            r_res_left <= w_done ? '0 : w_left;
            r_res_none <= 1'b0;
            r_res_full <= 1'b0;
        end

        if (i_cmd.emit) begin
            r_out_id   <= r_res_id;
            r_out_done <= r_res_done;
            r_out_left <= r_res_left;
            r_out_none <= r_res_none;
            r_out_full <= r_res_full;
        end
    end

    assign o_sts.found     = w_hit;
    assign o_sts.last_step = (r_step == STEP_W'(NSTEP - 1));
    assign o_sts.out_free  = !r_out_valid || o_result.ready;

    assign o_result.valid      = r_out_valid;
    assign o_result.process_id = r_out_id;
    assign o_result.completed  = r_out_done;
    assign o_result.time_left  = r_out_left;
    assign o_result.no_process = r_out_none;
    assign o_result.table_full = r_out_full;

    // an add item never reaches the slice path
    a_mode_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_exec |-> (r_mode == MODE_RUN))
        else $error("slice applied for an add item");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CNT_W'(MAX_PROCESSES))
        else $error("free count past table depth");

    a_exec_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_exec |-> r_active[r_slot])
        else $error("slice applied to inactive slot");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> (r_out_left == '0))
        else $error("completed process with time left");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_out_done, r_out_none, r_out_full}))
        else $error("conflicting result flags");

endmodule

### rtl/core/rrs_ctrl.sv
// Scheduler controller: sequences add, search, slice and result transfer.
// Depends on rrs_pkg.
module rrs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_mode,
    output logic              o_in_ready,
    input  rrs_pkg::t_dp_sts  i_sts,
    output rrs_pkg::t_dp_cmd  o_cmd
);
    import rrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_EXEC,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   w_accept;

    assign w_accept   = r_in_ready && i_in_valid;
    assign o_in_ready = r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_item = 1'b1;
                    if (i_in_mode == MODE_ADD) begin
                        n_state = S_ADD;
                    end else begin
                        o_cmd.start_scan = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_ADD: begin
                o_cmd.do_add = 1'b1;
                n_state      = S_OUT;
            end
            S_SCAN: begin
                if (i_sts.found) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = S_EXEC;
                end else if (i_sts.last_step) begin
                    o_cmd.set_none = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_EXEC: begin
                o_cmd.do_exec = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ready stays low in reset, rises on the first cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_in_ready)
        else $error("input ready while busy");

    a_hit_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_hit |=> (r_state == S_EXEC))
        else $error("search hit did not lead to slice");

    a_emit_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_in_ready)
        else $error("not ready after result staged");

endmodule

### rtl/core/round_robin_scheduler_core.sv
// Round-robin time-slice scheduler core: controller plus datapath.
// Depends on rrs_pkg, rrs_in_if, rrs_out_if, rrs_ctrl, rrs_datapath.
//
// Keeps a table of MAX_PROCESSES process slots. An item with mode 0 adds a
// process in the next unused slot (slots are handed out once, in arrival
// order; id = slot + 1) and returns its id and burst time, or table_full
// when every slot has been used. An item with mode 1 finds the next active
// slot in circular order from the current position, subtracts the
// time_slice register and returns id and time left; a process whose time
// does not exceed the slice is reported completed and removed. A run with
// nothing active returns no_process. One result per item. Items are taken
// one at a time: input ready is low from an accepted item until the
// controller is back in its idle state. The search checks up to 16 slots
// per cycle in a window that starts at the current position and moves on
// until it finds an active slot or has covered the table. A run that finds
// a process also passes through the registered read of the process table.
// The result sits in an output register, so the next item is taken while
// it waits for its transfer; a later result waits until an earlier one
// has left that register. Input ready is low during reset and rises on the
// first cycle after it.
// time_slice is written through i_cfg_we/i_cfg_wdata; the user must write it only while idle (not enforced).
// No clearing pass after reset: the table is read only for active slots.
module round_robin_scheduler_core #(
    parameter int MAX_PROCESSES = rrs_pkg::MAX_PROC_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rrs_pkg::TIME_W-1:0]  i_cfg_wdata,
    rrs_in_if.sink                      i_item,
    rrs_out_if.source                   o_result
);
    import rrs_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_item.ready = w_in_ready;

    // sequencing
    rrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_mode  (i_item.mode),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // table, search, arithmetic, result register
    rrs_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mode       (i_item.mode),
        .i_burst_time (i_item.burst_time),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_result     (o_result)
    );

endmodule

### dv/tb_round_robin_scheduler_core.sv
`timescale 1ns / 100ps
// Self-checking bench for round_robin_scheduler_core: adds, slice runs, slice register.
// Depends on rrs_pkg, rrs_in_if, rrs_out_if and the core; predicts every result in a class.

typedef struct packed {
    logic [rrs_pkg::ID_W-1:0]   process_id;
    logic                       completed;
    logic [rrs_pkg::TIME_W-1:0] time_left;
    logic                       no_process;
    logic                       table_full;
} rr_outcome_t;

// Tracks the process table and holds the outcomes still owed by the core.
class rr_sched_scoreboard;
    localparam int NPROC = rrs_pkg::MAX_PROC_DEF;

    logic [rrs_pkg::TIME_W-1:0] quantum;
    logic [rrs_pkg::TIME_W-1:0] slot_time [NPROC];
    bit                         slot_busy [NPROC];
    int                         slots_issued;
    int                         scan_from;
    rr_outcome_t                outcome_q[$];
    int                         mismatch_cnt;

    function new();
        quantum      = rrs_pkg::SLICE_RESET;
        slots_issued = 0;
        scan_from    = 0;
        mismatch_cnt = 0;
        foreach (slot_busy[s]) begin
            slot_busy[s] = 1'b0;
            slot_time[s] = '0;
        end
    endfunction

    function int pending();
        return outcome_q.size();
    endfunction

    // Apply one accepted item to the table and queue the outcome it must produce.
    function void schedule_item(logic mode, logic [rrs_pkg::TIME_W-1:0] burst);
        rr_outcome_t r;
        bit          hit;
        int          slot;
        int          s;
        r    = '0;
        hit  = 1'b0;
        slot = 0;
        if (mode == rrs_pkg::MODE_ADD) begin
            if (slots_issued >= NPROC) begin
                r.table_full = 1'b1;
            end else begin
                slot_time[slots_issued] = burst;
                slot_busy[slots_issued] = 1'b1;
                r.process_id = rrs_pkg::ID_W'(slots_issued + 1);
                r.time_left  = burst;
                slots_issued++;
            end
        end else begin
            for (int k = 0; k < NPROC; k++) begin
                s = (scan_from + k) % NPROC;
                if (!hit && slot_busy[s]) begin
                    hit  = 1'b1;
                    slot = s;
                end
            end
            if (!hit) begin
                r.no_process = 1'b1;
            end else begin
                scan_from    = (slot + 1) % NPROC;
                r.process_id = rrs_pkg::ID_W'(slot + 1);
                if (slot_time[slot] <= quantum) begin
                    slot_busy[slot] = 1'b0;
                    slot_time[slot] = '0;
                    r.completed     = 1'b1;
                end else begin
                    slot_time[slot] = slot_time[slot] - quantum;
                    r.time_left     = slot_time[slot];
                end
            end
        end
        outcome_q.push_back(r);
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] got);
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        mismatch_cnt++;
    endfunction

    function void check_result(rr_outcome_t got);
        rr_outcome_t want;
        if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            mismatch_cnt++;
            return;
        end
        want = outcome_q.pop_front();
        if (got.process_id !== want.process_id)
            flag("process_id", 16'(want.process_id), 16'(got.process_id));
        if (got.completed !== want.completed)
            flag("completed", 16'(want.completed), 16'(got.completed));
        if (got.time_left !== want.time_left)
            flag("time_left", want.time_left, got.time_left);
        if (got.no_process !== want.no_process)
            flag("no_process", 16'(want.no_process), 16'(got.no_process));
        if (got.table_full !== want.table_full)
            flag("table_full", 16'(want.table_full), 16'(got.table_full));
    endfunction
endclass

module tb_round_robin_scheduler_core;

    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int HOLD_CYCLES  = 60;      // long result back-pressure
    localparam int DRAIN_CYCLES = 12;      // settle time after the last result

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [rrs_pkg::TIME_W-1:0] i_cfg_wdata;

    rrs_in_if  item_if ();
    rrs_out_if res_if ();

    rr_sched_scoreboard sb;

    int send_gap_pct = 0;  // chance per cycle that the sender idles
    int stall_pct    = 0;  // chance per cycle that the receiver stalls
    bit hold_req     = 1'b0;
    int hold_left    = 0;
    int cycle_cnt    = 0;

    round_robin_scheduler_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item     (item_if),
        .o_result   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request. The hold is
    // counted here so the sender keeps offering items meanwhile and the core
    // backs up into its input.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Transfers are sampled on the rising edge, before the core updates.
    // The result check runs first; its outcome was queued cycles earlier.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready)
                sb.check_result(rr_outcome_t'{res_if.process_id, res_if.completed,
                                              res_if.time_left, res_if.no_process,
                                              res_if.table_full});
            if (item_if.valid && item_if.ready)
                sb.schedule_item(item_if.mode, item_if.burst_time);
        end
    end

    // Entered and left on a falling edge. Valid stays high from one item to the
    // next unless the sender decides to idle.
    task automatic send_item(input logic mode, input logic [rrs_pkg::TIME_W-1:0] burst);
        while ($urandom_range(99) < send_gap_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.mode       <= mode;
        item_if.burst_time <= burst;
        do @(posedge i_clk); while (!item_if.ready);
        @(negedge i_clk);
    endtask

    // Sender goes quiet until every owed result has come back.
    task automatic pause_until_drained();
        item_if.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // Slice register is only touched with the core idle.
    task automatic write_slice(input logic [rrs_pkg::TIME_W-1:0] value);
        pause_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.quantum = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly runs, a few adds (the table fills and then
    // rejects), bursts skewed small so processes finish within the run.
    task automatic run_phase(input int n_items, input int gap_pct, input int stall,
                             input logic [rrs_pkg::TIME_W-1:0] slice, input bit squeeze);
        logic                       mode;
        logic [rrs_pkg::TIME_W-1:0] burst;
        int                         pick;
        write_slice(slice);
        send_gap_pct = gap_pct;
        stall_pct    = stall;
        for (int i = 0; i < n_items; i++) begin
            mode = ($urandom_range(99) < 10) ? rrs_pkg::MODE_ADD : rrs_pkg::MODE_RUN;
            pick = $urandom_range(9);
            if (pick < 4)
                burst = rrs_pkg::TIME_W'($urandom_range(64));
            else if (pick < 7)
                burst = rrs_pkg::TIME_W'($urandom_range(1000));
            else
                burst = rrs_pkg::TIME_W'($urandom);
            if (squeeze && i == 40)
                hold_req = 1'b1;
            if (squeeze && i == 120)
                pause_until_drained();
            send_item(mode, burst);
        end
    endtask

    initial begin
        sb                 = new();
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        item_if.valid      = 1'b0;
        item_if.mode       = rrs_pkg::MODE_ADD;
        item_if.burst_time = '0;
        res_if.ready       = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset slice of 1.
        send_item(rrs_pkg::MODE_RUN, 16'h1234);   // empty table
        send_item(rrs_pkg::MODE_ADD, 16'h0000);   // id 1, zero burst
        send_item(rrs_pkg::MODE_ADD, 16'hFFFF);   // id 2, max burst
        send_item(rrs_pkg::MODE_ADD, 16'h0001);   // id 3
        send_item(rrs_pkg::MODE_ADD, 16'h0002);   // id 4
        send_item(rrs_pkg::MODE_RUN, 16'hFFFF);   // head finishes at once
        send_item(rrs_pkg::MODE_RUN, 16'h0000);   // id 2 down by one
        send_item(rrs_pkg::MODE_RUN, 16'h0000);   // id 3 finishes
        send_item(rrs_pkg::MODE_RUN, 16'h0000);   // id 4 down to 1
        send_item(rrs_pkg::MODE_RUN, 16'h0000);   // wraps back to id 2
        send_item(rrs_pkg::MODE_RUN, 16'h0000);   // id 4 finishes
        send_item(rrs_pkg::MODE_RUN, 16'h0000);   // id 2 alone
        send_item(rrs_pkg::MODE_RUN, 16'h0000);   // id 2 alone again

        // Widest slice: the lone process finishes, then nothing is left.
        write_slice(16'hFFFF);
        send_item(rrs_pkg::MODE_RUN, 16'h0000);
        send_item(rrs_pkg::MODE_RUN, 16'h0000);
        send_item(rrs_pkg::MODE_ADD, 16'h5555);
        send_item(rrs_pkg::MODE_ADD, 16'hAAAA);
        send_item(rrs_pkg::MODE_RUN, 16'h0000);
        send_item(rrs_pkg::MODE_RUN, 16'h0000);
        send_item(rrs_pkg::MODE_RUN, 16'h0000);

        // Random phases: free flow, sender gaps, receiver stalls, both.
        run_phase(235, 0, 0, 16'd1, 1'b1);
        run_phase(235, 60, 0, rrs_pkg::TIME_W'($urandom_range(300, 2)), 1'b0);
        run_phase(235, 0, 60, rrs_pkg::TIME_W'($urandom_range(65534, 301)), 1'b0);
        run_phase(235, 17, 17, 16'hFFFF, 1'b0);

        item_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
rtl/core/rrs_pkg.sv
rtl/core/rrs_in_if.sv
rtl/core/rrs_out_if.sv
rtl/core/rrs_datapath.sv
rtl/core/rrs_ctrl.sv
rtl/core/round_robin_scheduler_core.sv
dv/tb_round_robin_scheduler_core.sv
